/* rtl/linked_task_queue_manager_defines.svh */
// assertion macros shared by the linked task queue manager rtl
`ifndef LINKED_TASK_QUEUE_MANAGER_DEFINES_SVH
`define LINKED_TASK_QUEUE_MANAGER_DEFINES_SVH

// concurrent assertion on an explicit clock and active-low reset
`define LTQM_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define LTQM_ASSERT(lbl, prop, msg) \
  `LTQM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* rtl/ltqm_pkg.sv */
// types and constants of the linked task queue manager
package ltqm_pkg;

  localparam int NUM_SLOTS_DEF  = 16;
  localparam int NUM_QUEUES_DEF = 4;

  // field widths on the stream ports
  localparam int REQ_W    = 3;
  localparam int QID_W    = 2;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;

  // input word layout
  localparam int REQ_LSB    = 0;
  localparam int QID_LSB    = REQ_LSB + REQ_W;
  localparam int SLOT_LSB   = QID_LSB + QID_W;
  localparam int IN_DATA_W  = 16;

  // output word layout
  localparam int OUT_USED_W = SLOT_W + 3 + STATUS_W;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_POP    = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_CHECK  = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_POP_EMPTY = 2'd1,
    STS_BAD_SLOT  = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // update strobes for the per-queue and per-slot registers
  typedef struct packed {
    logic set_head;
    logic set_tail;
    logic set_ne;
    logic clr_ne;
    logic set_own;
    logic clr_own;
    logic own_side;  // 1: owner kept in the next-link entry, 0: in the prev-link entry
  } tbl_ctl_t;

endpackage

/* rtl/linked_task_queue_manager.sv */
// top level of the linked task queue manager
//
// keeps NUM_QUEUES doubly linked queues of task slots 0..NUM_SLOTS-1
// input words (s_axis): append at tail, insert at head, pop head, remove a
// slot (returns its successor) or check membership, on one queue
// output words (m_axis): one result per input word, same order
// flow: in idle the word is accepted and the link and owner entries are
// read from the two link rams into registered outputs; in exec the block
// modifies and writes back both rams and the per-queue registers and loads
// the result; no new word is accepted until that write-back is done, as
// each word makes a read-then-write pass through the link rams
// the result register lets the next word be accepted while a result waits;
// if the receiver stalls with a result still pending, the write-back
// holds until the pending result is taken, then input waits in turn
// reset: all queues empty and no slot owned; link rams need no clearing, an
// entry is only used while its slot is owned
`include "linked_task_queue_manager_defines.svh"

module linked_task_queue_manager #(
  parameter int NUM_SLOTS  = ltqm_pkg::NUM_SLOTS_DEF,
  parameter int NUM_QUEUES = ltqm_pkg::NUM_QUEUES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [2:0] req_type, [4:3] queue_id, [8:5] slot, [15:9] zero
  input  logic [ltqm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [3:0] slot_out, [4] slot_out_valid, [5] found, [6] queue_empty,
  // [8:7] status, [15:9] zero
  output logic [ltqm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  import ltqm_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int EW = QW + SW;  // link ram entry: {owner queue, link}

  // fsm
  state_e state_q, state_d;
  logic   accept, done;

  // request fields
  logic [REQ_W-1:0]  req_in;
  logic [QID_W-1:0]  qid_in;
  logic [SLOT_W-1:0] slot_in;
  logic [QW-1:0]     qidx_in;
  logic [SW-1:0]     sidx_in;
  logic              slot_ok_in, queue_ok_in;

  // registered request
  req_e          req_q;
  logic [QW-1:0] qid_q;
  logic [SW-1:0] sidx_q;
  logic          slot_ok_q, queue_ok_q;

  // table lookups (registered at accept)
  logic [SW-1:0] hd, tl;
  logic          ne, own_s, side_s;
  logic [SW-1:0] rd_addr;
  // head of the requested queue, used to address the rams on a pop
  logic [SW-1:0] hd_now;

  // link rams
  logic [EW-1:0] nx_rdata, pv_rdata;
  logic          nx_we, pv_we;
  logic [SW-1:0] nx_waddr, pv_waddr;
  logic [EW-1:0] nx_wdata, pv_wdata;

  // write-back
  tbl_ctl_t      ctl, ctl_go;
  logic [SW-1:0] head_new, tail_new, tgt;

  // result
  logic [SLOT_W-1:0] res_slot;
  logic              res_valid, res_found, res_empty;
  status_e           res_status;
  logic              m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  // request decode
  assign req_in      = s_axis_tdata[REQ_LSB +: REQ_W];
  assign qid_in      = s_axis_tdata[QID_LSB +: QID_W];
  assign slot_in     = s_axis_tdata[SLOT_LSB +: SLOT_W];
  assign qidx_in     = QW'(qid_in);
  assign sidx_in     = SW'(slot_in);
  assign slot_ok_in  = 32'(slot_in) < 32'(NUM_SLOTS);
  assign queue_ok_in = 32'(qid_in) < 32'(NUM_QUEUES);

  // fsm next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    s_axis_tready = 1'b0;
    done          = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EXEC: done          = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= req_e'(req_in);
      qid_q      <= qidx_in;
      sidx_q     <= sidx_in;
      slot_ok_q  <= slot_ok_in;
      queue_ok_q <= queue_ok_in;
    end
  end

  // pop works on the head, everything else on the named slot
  assign rd_addr = (req_e'(req_in) == REQ_POP) ? hd_now : sidx_in;

  ltqm_tables #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_QUEUES (NUM_QUEUES),
    .SW         (SW),
    .QW         (QW)
  ) u_tables (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_q_i     (qidx_in),
    .rd_s_i     (sidx_in),
    .head_o     (hd),
    .tail_o     (tl),
    .nonempty_o (ne),
    .owned_o    (own_s),
    .side_o     (side_s),
    .head_now_o (hd_now),
    .ctl_i      (ctl_go),
    .wr_q_i     (qid_q),
    .wr_s_i     (tgt),
    .head_i     (head_new),
    .tail_i     (tail_new)
  );

  ltqm_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_SLOTS)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we && done),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (nx_rdata)
  );

  ltqm_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_SLOTS)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pv_we && done),
    .waddr_i (pv_waddr),
    .wdata_i (pv_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (pv_rdata)
  );

  // read-modify-write of the addressed queue
  logic [SW-1:0] nx_link, pv_link;
  logic [QW-1:0] owner_s;
  logic          in_q, is_head, is_tail, ne_after, do_unlink;

  assign nx_link = nx_rdata[SW-1:0];
  assign pv_link = pv_rdata[SW-1:0];
  // owner copy lives in whichever entry the slot's push wrote
  assign owner_s = side_s ? nx_rdata[EW-1:SW] : pv_rdata[EW-1:SW];
  assign in_q    = slot_ok_q && own_s && (owner_s == qid_q);
  assign tgt     = (req_q == REQ_POP) ? hd : sidx_q;
  assign is_head = (hd == tgt);
  assign is_tail = (tl == tgt);

  always_comb begin
    nx_we      = 1'b0;
    nx_waddr   = tgt;
    nx_wdata   = '0;
    pv_we      = 1'b0;
    pv_waddr   = tgt;
    pv_wdata   = '0;
    ctl        = '0;
    head_new   = hd;
    tail_new   = tl;
    res_slot   = '0;
    res_valid  = 1'b0;
    res_found  = 1'b0;
    res_status = STS_OK;
    ne_after   = ne;
    do_unlink  = 1'b0;

    if (!queue_ok_q) begin
      res_status = STS_BAD_SLOT;
      ne_after   = 1'b0;
    end else begin
      case (req_q)
        REQ_APPEND: begin
          if (!slot_ok_q || own_s) begin
            res_status = STS_BAD_SLOT;
          end else begin
            if (ne) begin
              nx_we    = 1'b1;
              nx_waddr = tl;
              nx_wdata = {qid_q, sidx_q};
            end
            // prev entry of the new slot also holds its owner
            pv_we        = 1'b1;
            pv_waddr     = sidx_q;
            pv_wdata     = {qid_q, (ne ? tl : sidx_q)};
            ctl.set_tail = 1'b1;
            tail_new     = sidx_q;
            ctl.set_head = !ne;
            head_new     = sidx_q;
            ctl.set_ne   = 1'b1;
            ctl.set_own  = 1'b1;
            ctl.own_side = 1'b0;
            ne_after     = 1'b1;
          end
        end
        REQ_INSERT: begin
          if (!slot_ok_q || own_s) begin
            res_status = STS_BAD_SLOT;
          end else begin
            if (ne) begin
              pv_we    = 1'b1;
              pv_waddr = hd;
              pv_wdata = {qid_q, sidx_q};
            end
            // next entry of the new slot also holds its owner
            nx_we        = 1'b1;
            nx_waddr     = sidx_q;
            nx_wdata     = {qid_q, (ne ? hd : sidx_q)};
            ctl.set_head = 1'b1;
            head_new     = sidx_q;
            ctl.set_tail = !ne;
            tail_new     = sidx_q;
            ctl.set_ne   = 1'b1;
            ctl.set_own  = 1'b1;
            ctl.own_side = 1'b1;
            ne_after     = 1'b1;
          end
        end
        REQ_POP: begin
          if (!ne) begin
            res_status = STS_POP_EMPTY;
          end else begin
            do_unlink = 1'b1;
            res_slot  = SLOT_W'(hd);
            res_valid = 1'b1;
          end
        end
        REQ_REMOVE: begin
          if (!in_q) begin
            res_status = STS_BAD_SLOT;
          end else begin
            do_unlink = 1'b1;
            // the tail has no successor
            res_valid = !is_tail;
            res_slot  = is_tail ? '0 : SLOT_W'(nx_link);
          end
        end
        REQ_CHECK: res_found = in_q;
        default: ;
      endcase

      if (do_unlink) begin
        ctl.clr_own = 1'b1;
        if (is_head && is_tail) begin
          ctl.clr_ne = 1'b1;
          ne_after   = 1'b0;
        end else if (is_head) begin
          ctl.set_head = 1'b1;
          head_new     = nx_link;
        end else if (is_tail) begin
          ctl.set_tail = 1'b1;
          tail_new     = pv_link;
        end else begin
          // middle slot: splice its neighbours together
          nx_we    = 1'b1;
          nx_waddr = pv_link;
          nx_wdata = {qid_q, nx_link};
          pv_we    = 1'b1;
          pv_waddr = nx_link;
          pv_wdata = {qid_q, pv_link};
        end
      end
    end
    res_empty = !ne_after;
  end

  assign ctl_go = done ? ctl : '0;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      m_data_q <= {{OUT_PAD_W{1'b0}}, res_status, res_empty, res_found, res_valid, res_slot};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // a finished write-back always leaves a result for the receiver
  `LTQM_ASSERT(a_done_gives_result, done |=> m_axis_tvalid, "write-back without result")
  // no new word is taken while the rams are being written back
  `LTQM_ASSERT(a_no_accept_in_exec, (state_q == ST_EXEC) |-> !s_axis_tready,
    "input accepted during write-back")
  // a refused pop never carries a slot
  `LTQM_ASSERT(a_pop_empty_no_slot,
    (m_axis_tvalid && (m_axis_tdata[8:7] == STS_POP_EMPTY)) |-> !m_axis_tdata[4],
    "pop on empty queue returned a slot")
  // membership is only reported on a clean request
  `LTQM_ASSERT(a_found_ok, (m_axis_tvalid && m_axis_tdata[5]) |-> (m_axis_tdata[8:7] == STS_OK),
    "found with error status")

endmodule

/* rtl/ltqm_ram.sv */
// generic single-port-write ram with registered read
module ltqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ltqm_tables.sv */
// per-queue head, tail and non-empty registers and per-slot ownership bits
module ltqm_tables #(
  parameter int NUM_SLOTS  = ltqm_pkg::NUM_SLOTS_DEF,
  parameter int NUM_QUEUES = ltqm_pkg::NUM_QUEUES_DEF,
  parameter int SW         = $clog2(NUM_SLOTS),
  parameter int QW         = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // lookup, registered
  input  logic               rd_en_i,
  input  logic [QW-1:0]      rd_q_i,
  input  logic [SW-1:0]      rd_s_i,
  output logic [SW-1:0]      head_o,
  output logic [SW-1:0]      tail_o,
  output logic               nonempty_o,
  output logic               owned_o,
  output logic               side_o,
  // current head of the looked-up queue, combinational
  output logic [SW-1:0]      head_now_o,
  // update
  input  ltqm_pkg::tbl_ctl_t ctl_i,
  input  logic [QW-1:0]      wr_q_i,
  input  logic [SW-1:0]      wr_s_i,
  input  logic [SW-1:0]      head_i,
  input  logic [SW-1:0]      tail_i
);

  import ltqm_pkg::*;

  logic [SW-1:0] head_q [NUM_QUEUES];
  logic [SW-1:0] tail_q [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] nonempty_q;
  logic [NUM_SLOTS-1:0]  owned_q;
  logic [NUM_SLOTS-1:0]  side_q;

  logic [SW-1:0] head_rd_q, tail_rd_q;
  logic          ne_rd_q, owned_rd_q, side_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= '0;
      owned_q    <= '0;
    end else begin
      if (ctl_i.set_ne) begin
        nonempty_q[wr_q_i] <= 1'b1;
      end else if (ctl_i.clr_ne) begin
        nonempty_q[wr_q_i] <= 1'b0;
      end
      if (ctl_i.set_own) begin
        owned_q[wr_s_i] <= 1'b1;
      end else if (ctl_i.clr_own) begin
        owned_q[wr_s_i] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.set_head) begin
      head_q[wr_q_i] <= head_i;
    end
    if (ctl_i.set_tail) begin
      tail_q[wr_q_i] <= tail_i;
    end
    if (ctl_i.set_own) begin
      side_q[wr_s_i] <= ctl_i.own_side;
    end
    if (rd_en_i) begin
      head_rd_q  <= head_q[rd_q_i];
      tail_rd_q  <= tail_q[rd_q_i];
      ne_rd_q    <= nonempty_q[rd_q_i];
      owned_rd_q <= owned_q[rd_s_i];
      side_rd_q  <= side_q[rd_s_i];
    end
  end

  assign head_o     = head_rd_q;
  assign tail_o     = tail_rd_q;
  assign nonempty_o = ne_rd_q;
  assign owned_o    = owned_rd_q;
  assign side_o     = side_rd_q;
  assign head_now_o = head_q[rd_q_i];

endmodule
